// File: hdl/fpba_pkg.sv
// Package for the fit-policy block allocator: sizes, policy codes, register indexes.
package fpba_pkg;

  localparam int unsigned NumBlocksDef = 16;
  localparam int unsigned SizeBitsDef  = 16;

  localparam int unsigned SlotW   = 4;
  localparam int unsigned ItemW   = 16;
  localparam int unsigned CountW  = 5;
  localparam int unsigned PolicyW = 2;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned DataW   = 24;

  localparam logic [PolicyW-1:0] POLICY_FIRST = 2'd0;
  localparam logic [PolicyW-1:0] POLICY_BEST  = 2'd1;
  localparam logic [PolicyW-1:0] POLICY_WORST = 2'd2;

  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

endpackage

// File: hdl/fit_policy_block_allocator.sv
// Fit-policy block allocator: capacity table, sequential scan and grant logic.
//
// Channel | Port prefix | Payload
// input   | in_         | tuser: mode; tdata: block_slot[3:0], item_size[19:4]; tlast: batch_end
// result  | out_        | tuser: granted; tdata: chosen_block[3:0], capacity_left[19:4];
//         |             | tlast: batch_last
// config  | cfg_        | wr_en, index (0 fit_policy, 1 block_count), wr_data
//
// A load item gives no result.
// A request scans the first limit table entries,
// limit = min(block_count, NUM_BLOCKS):
// one table read per cycle through the single read port, one compare per entry.
// in_tready is low from request accept until the result item is taken.
// Reset clears the table (per-entry valid bits) and control flags; policy = first, count = 16.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NumBlocksDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DataW-1:0]  in_tdata,   // block_slot, item_size, zero pad
  input  logic              in_tuser,   // mode
  input  logic              in_tlast,   // batch_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DataW-1:0]  out_tdata,  // chosen_block, capacity_left, zero pad
  output logic              out_tuser,  // granted
  output logic              out_tlast,  // batch_last
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [CfgW-1:0]   cfg_wr_data
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_OUT} state_t;

  state_t               state_r, state_nxt;
  logic [PolicyW-1:0]   policy_r;
  logic [CountW-1:0]    count_r;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 last_r, last_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]     p_idx_r, p_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_granted_r, out_granted_nxt;
  logic [SlotW-1:0]     out_block_r, out_block_nxt;
  logic [ItemW-1:0]     out_cap_r, out_cap_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] ent_vld_r;
  logic [SIZE_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic                 in_fire;
  logic [SlotW-1:0]     in_slot;
  logic [ItemW-1:0]     in_size;
  logic [31:0]          slot_w, size_w, cnt_w, lim_w, pick_w, cap_w;
  logic                 slot_ok;
  logic [IDX_W-1:0]     load_addr, wr_addr;
  logic [SIZE_BITS-1:0] wr_data, new_cap, cap_q;
  logic                 we, fits, take;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_slot   = in_tdata[SlotW-1:0];
  assign in_size   = in_tdata[SlotW +: ItemW];
  assign slot_w    = 32'(in_slot);
  assign size_w    = 32'(in_size);
  assign cnt_w     = 32'(count_r);
  assign lim_w     = (cnt_w > NUM_BLOCKS) ? NUM_BLOCKS : cnt_w;
  assign slot_ok   = (slot_w < NUM_BLOCKS);
  assign load_addr = slot_w[IDX_W-1:0];

  assign new_cap = best_r - size_r;
  assign pick_w  = 32'(pick_r);
  assign cap_w   = 32'(new_cap);
  assign cap_q   = rd_vld_r ? rd_data_r : '0;
  assign fits    = (cap_q >= size_r);

  always_comb begin
    take = 1'b0;
    if (p_vld_r && fits) begin
      if (!found_r) take = 1'b1;
      else if (policy_r == POLICY_BEST) take = (cap_q < best_r);
      else if (policy_r == POLICY_WORST) take = (cap_q > best_r);
    end
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = load_addr;
    wr_data = size_w[SIZE_BITS-1:0];
    if (in_fire && in_tuser == MODE_LOAD && slot_ok) begin
      we = 1'b1;
    end else if (state_r == ST_UPDATE && found_r) begin
      we      = 1'b1;
      wr_addr = pick_r;
      wr_data = new_cap;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    size_nxt        = size_r;
    last_nxt        = last_r;
    limit_nxt       = limit_r;
    idx_nxt         = idx_r;
    p_vld_nxt       = 1'b0;
    p_idx_nxt       = idx_r[IDX_W-1:0];
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    best_nxt        = best_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_granted_nxt = out_granted_r;
    out_block_nxt   = out_block_r;
    out_cap_nxt     = out_cap_r;
    out_last_nxt    = out_last_r;
    if (take) begin
      found_nxt = 1'b1;
      pick_nxt  = p_idx_r;
      best_nxt  = cap_q;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tuser == MODE_REQUEST) begin
          size_nxt  = size_w[SIZE_BITS-1:0];
          last_nxt  = in_tlast;
          limit_nxt = lim_w[CNT_W-1:0];
          idx_nxt   = '0;
          found_nxt = 1'b0;
          pick_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r < limit_r) begin
          p_vld_nxt = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end else if (!p_vld_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        out_tvalid_nxt  = 1'b1;
        out_granted_nxt = found_r;
        out_block_nxt   = found_r ? pick_w[SlotW-1:0] : '0;
        out_cap_nxt     = found_r ? cap_w[ItemW-1:0] : '0;
        out_last_nxt    = last_r;
        state_nxt       = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_tvalid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      policy_r     <= POLICY_FIRST;
      count_r      <= CountW'(16);
      p_vld_r      <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      p_vld_r      <= p_vld_nxt;
      found_r      <= found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FIT_POLICY:  policy_r <= cfg_wr_data[PolicyW-1:0];
          CFG_BLOCK_COUNT: count_r  <= cfg_wr_data[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r        <= size_nxt;
    last_r        <= last_nxt;
    limit_r       <= limit_nxt;
    idx_r         <= idx_nxt;
    p_idx_r       <= p_idx_nxt;
    pick_r        <= pick_nxt;
    best_r        <= best_nxt;
    out_granted_r <= out_granted_nxt;
    out_block_r   <= out_block_nxt;
    out_cap_r     <= out_cap_nxt;
    out_last_r    <= out_last_nxt;
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (we) ent_vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= ent_vld_r[idx_r[IDX_W-1:0]];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_granted_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(DataW - SlotW - ItemW){1'b0}}, out_cap_r, out_block_r};

  a_ready_xor_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_not_granted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("refused request carries nonzero payload");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == ST_SCAN))
    else $error("scan data outside scan state");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r != ST_IDLE) |-> (32'(pick_r) < 32'(limit_r)))
    else $error("chosen block outside scanned range");

  a_request_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == MODE_REQUEST) |=> (state_r == ST_SCAN && !found_r))
    else $error("request did not start a scan");

endmodule
